@@ rtl/core/power_monitor_report_filter_macros.svh @@
// Assertion macros used by the power monitor report filter checker.
`ifndef POWER_MONITOR_REPORT_FILTER_MACROS_SVH
`define POWER_MONITOR_REPORT_FILTER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while in reset.
`define PMRF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while in reset.
`define PMRF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/pmrf_pkg.sv @@
// Shared types and constants of the power monitor report filter.
package pmrf_pkg;

	// Event kinds carried by an input item.
	typedef enum logic [1:0] {
		OP_GOOD  = 2'd0,
		OP_WEDGE = 2'd1,
		OP_NACK  = 2'd2,
		OP_TICK  = 2'd3
	} op_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_ENABLE    = 3'd0,
		REG_PERIOD    = 3'd1,
		REG_MV_THRESH = 3'd2,
		REG_UA_THRESH = 3'd3,
		REG_HEARTBEAT = 3'd4,
		REG_ERR_LIMIT = 3'd5
	} cfg_reg_t;

	// Back-end sequencer states.
	typedef enum logic [1:0] {
		BK_IDLE   = 2'd0,
		BK_MUL    = 2'd1,
		BK_SCALE  = 2'd2,
		BK_DECIDE = 2'd3
	} back_state_t;

	// One queued item after classification.
	typedef struct packed {
		op_t                op;
		logic [31:0]        now_ms;
		logic [15:0]        bus_raw;
		logic signed [15:0] shunt_raw;
	} item_t;

	// Configuration register file contents.
	typedef struct packed {
		logic        report_enable;
		logic [15:0] report_period_ms;
		logic [16:0] change_mv_threshold;
		logic [24:0] change_ua_threshold;
		logic [30:0] heartbeat_ms;
		logic [3:0]  recover_error_limit;
	} cfg_t;

	// Register values after reset.
	localparam logic [15:0] PERIOD_RST    = 16'd1000;
	localparam logic [16:0] MV_THRESH_RST = 17'd50;
	localparam logic [24:0] UA_THRESH_RST = 25'd20000;
	localparam logic [30:0] HEARTBEAT_RST = 31'd15000;
	localparam logic [3:0]  ERR_LIMIT_RST = 4'd3;

	// Microamps per shunt LSB.
	localparam logic signed [24:0] UA_PER_LSB = 25'sd500;

	// Power in mW is mV * shunt / 2000: shift by 4, then divide by 125 through
	// a reciprocal ceil(2^35 / 125), exact for a dividend below 2^28.
	localparam logic [28:0] RECIP_125   = 29'd274877907;
	localparam int          RECIP_SHIFT = 35;

endpackage

@@ rtl/core/pmrf_front.sv @@
// Front end: accepts items, classifies the event kind and queues them.
module pmrf_front import pmrf_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         operation,
	input  logic [31:0]        now_ms,
	input  logic [15:0]        bus_raw,
	input  logic signed [15:0] shunt_raw,
	output logic               head_valid,
	output item_t              head,
	input  logic               head_pop
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t              slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               push_ok;
	logic               pop_ok;
	item_t              incoming;

	// Classify the raw operation code into an event kind.
	always_comb begin
		incoming.op        = op_t'(operation);
		incoming.now_ms    = now_ms;
		incoming.bus_raw   = bus_raw;
		incoming.shunt_raw = shunt_raw;
	end

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_ptr_q];
	assign push_ok    = push && !full;
	assign pop_ok     = head_pop && head_valid;

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push_ok) begin
			slot_q[wr_ptr_q] <= incoming;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_ok && !pop_ok) begin
				count_q <= count_q + 1'b1;
			end else if (pop_ok && !push_ok) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/pmrf_back.sv @@
// Back end: scales samples, tracks failures, decides reports, holds the result.
module pmrf_back import pmrf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               head_valid,
	input  item_t              head,
	output logic               head_pop,
	output logic               empty,
	input  logic               pop,
	output logic [16:0]        volts_mv,
	output logic signed [24:0] current_ua,
	output logic signed [21:0] power_mw,
	output logic               measurement_valid,
	output logic               report_now,
	output logic               recover_bus
);

	back_state_t        state_q;
	back_state_t        state_n;
	logic               commit;

	item_t              item_s1;

	logic [18:0]        bus_x5;
	logic [16:0]        mv_calc;
	logic signed [24:0] ua_calc;
	logic signed [17:0] mv_ext;
	logic signed [33:0] prod;
	logic [31:0]        prod_mag;

	logic [16:0]        mv_s2;
	logic signed [24:0] ua_s2;
	logic [27:0]        quo_in_s2;
	logic               neg_s2;

	logic [56:0]        recip_prod;
	logic [20:0]        mw_mag_s3;

	// Held state.
	logic [16:0]        held_mv_q;
	logic signed [24:0] held_ua_q;
	logic signed [21:0] held_mw_q;
	logic               have_q;
	logic [3:0]         wedge_q;
	logic               once_q;
	logic [16:0]        rep_mv_q;
	logic signed [24:0] rep_ua_q;
	logic [31:0]        rep_time_q;
	logic [31:0]        deadline_q;

	// Decision results.
	logic [16:0]        mv_n;
	logic signed [24:0] ua_n;
	logic signed [21:0] mw_n;
	logic signed [21:0] mw_calc;
	logic               have_n;
	logic [3:0]         wedge_n;
	logic [3:0]         wedge_inc;
	logic               recover;
	logic [31:0]        due_diff;
	logic [31:0]        since;
	logic               beat;
	logic               eligible;
	logic               report;
	logic signed [17:0] dmv;
	logic [16:0]        dmv_abs;
	logic signed [25:0] dua;
	logic [24:0]        dua_abs;

	logic               out_valid_q;
	logic [16:0]        out_mv_q;
	logic signed [24:0] out_ua_q;
	logic signed [21:0] out_mw_q;
	logic               out_have_q;
	logic               out_report_q;
	logic               out_recover_q;

	// Next state of the sequencer.
	always_comb begin
		state_n = state_q;
		case (state_q)
			BK_IDLE: begin
				if (head_valid) begin
					state_n = BK_MUL;
				end
			end
			BK_MUL: begin
				state_n = BK_SCALE;
			end
			BK_SCALE: begin
				state_n = BK_DECIDE;
			end
			BK_DECIDE: begin
				if (!out_valid_q || pop) begin
					state_n = BK_IDLE;
				end
			end
			default: begin
				state_n = BK_IDLE;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		head_pop = 1'b0;
		commit   = 1'b0;
		case (state_q)
			BK_IDLE: begin
				head_pop = head_valid;
			end
			BK_DECIDE: begin
				commit = !out_valid_q || pop;
			end
			default: begin
				head_pop = 1'b0;
				commit   = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Take the item at the head of the queue.
	always_ff @(posedge clk) begin
		if (head_pop) begin
			item_s1 <= head;
		end
	end

	// Scaling: mV = floor(raw * 5 / 4), uA = shunt * 500, and the signed mV * shunt.
	assign bus_x5   = {3'b000, item_s1.bus_raw} + {1'b0, item_s1.bus_raw, 2'b00};
	assign mv_calc  = bus_x5[18:2];
	assign ua_calc  = 25'(item_s1.shunt_raw) * UA_PER_LSB;
	assign mv_ext   = $signed({1'b0, mv_calc});
	assign prod     = 34'(mv_ext) * 34'(item_s1.shunt_raw);
	assign prod_mag = prod[33] ? 32'(-prod) : prod[31:0];

	always_ff @(posedge clk) begin
		if (state_q == BK_MUL) begin
			mv_s2     <= mv_calc;
			ua_s2     <= ua_calc;
			quo_in_s2 <= prod_mag[31:4];
			neg_s2    <= prod[33];
		end
	end

	// Divide the magnitude by 125 through the reciprocal.
	assign recip_prod = 57'(quo_in_s2) * 57'(RECIP_125);

	always_ff @(posedge clk) begin
		if (state_q == BK_SCALE) begin
			mw_mag_s3 <= recip_prod[RECIP_SHIFT +: 21];
		end
	end

	assign mw_calc = neg_s2 ? -$signed({1'b0, mw_mag_s3}) : $signed({1'b0, mw_mag_s3});

	// Apply the event to the held measurement and the failure counter.
	assign wedge_inc = wedge_q + 4'd1;

	always_comb begin
		mv_n    = held_mv_q;
		ua_n    = held_ua_q;
		mw_n    = held_mw_q;
		have_n  = have_q;
		wedge_n = wedge_q;
		recover = 1'b0;
		case (item_s1.op)
			OP_GOOD: begin
				mv_n    = mv_s2;
				ua_n    = ua_s2;
				mw_n    = mw_calc;
				have_n  = 1'b1;
				wedge_n = '0;
			end
			OP_WEDGE: begin
				have_n = 1'b0;
				if (wedge_inc >= cfg.recover_error_limit) begin
					recover = 1'b1;
					wedge_n = '0;
				end else begin
					wedge_n = wedge_inc;
				end
			end
			OP_NACK: begin
				have_n  = 1'b0;
				wedge_n = '0;
			end
			default: begin
				have_n = have_q;
			end
		endcase
	end

	// Report decision: wrap-safe deadline, change thresholds and heartbeat.
	assign due_diff = item_s1.now_ms - deadline_q;
	assign since    = item_s1.now_ms - rep_time_q;
	assign beat     = !since[31] && (since[30:0] >= cfg.heartbeat_ms);
	assign dmv      = $signed({1'b0, mv_n}) - $signed({1'b0, rep_mv_q});
	assign dmv_abs  = dmv[17] ? 17'(-dmv) : dmv[16:0];
	assign dua      = 26'(ua_n) - 26'(rep_ua_q);
	assign dua_abs  = dua[25] ? 25'(-dua) : dua[24:0];
	assign eligible = cfg.report_enable && have_n && !due_diff[31];
	assign report   = eligible && (!once_q || (dmv_abs >= cfg.change_mv_threshold)
		|| (dua_abs >= cfg.change_ua_threshold) || beat);

	// State update when the result is written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_mv_q  <= '0;
			held_ua_q  <= '0;
			held_mw_q  <= '0;
			have_q     <= 1'b0;
			wedge_q    <= '0;
			once_q     <= 1'b0;
			rep_mv_q   <= '0;
			rep_ua_q   <= '0;
			rep_time_q <= '0;
			deadline_q <= '0;
		end else if (commit) begin
			held_mv_q <= mv_n;
			held_ua_q <= ua_n;
			held_mw_q <= mw_n;
			have_q    <= have_n;
			wedge_q   <= wedge_n;
			if (eligible) begin
				deadline_q <= item_s1.now_ms + 32'(cfg.report_period_ms);
			end
			if (report) begin
				once_q     <= 1'b1;
				rep_mv_q   <= mv_n;
				rep_ua_q   <= ua_n;
				rep_time_q <= item_s1.now_ms;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_mv_q      <= mv_n;
			out_ua_q      <= ua_n;
			out_mw_q      <= mw_n;
			out_have_q    <= have_n;
			out_report_q  <= report;
			out_recover_q <= recover;
		end
	end

	assign empty             = !out_valid_q;
	assign volts_mv          = out_mv_q;
	assign current_ua        = out_ua_q;
	assign power_mw          = out_mw_q;
	assign measurement_valid = out_have_q;
	assign report_now        = out_report_q;
	assign recover_bus       = out_recover_q;

endmodule

@@ rtl/core/power_monitor_report_filter.sv @@
// Each item passes the back end's four-step sequencer (take, scale, reciprocal
// divide, decide); the next item is taken once the result is written, and the
// decide step stalls while an earlier result waits to be popped. The input
// queue takes items while the back end works or a result waits to be popped.
// Reset (arst_n low) empties the input queue and output register, clears all
// held measurement and report state, and loads the configuration defaults.
module power_monitor_report_filter import pmrf_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         operation,
	input  logic [31:0]        now_ms,
	input  logic [15:0]        bus_raw,
	input  logic signed [15:0] shunt_raw,
	output logic               empty,
	input  logic               pop,
	output logic [16:0]        volts_mv,
	output logic signed [24:0] current_ua,
	output logic signed [21:0] power_mw,
	output logic               measurement_valid,
	output logic               report_now,
	output logic               recover_bus,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [30:0]        cfg_data
);

	cfg_t  cfg_q;
	logic  head_valid;
	item_t head;
	logic  head_pop;

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.report_enable       <= 1'b0;
			cfg_q.report_period_ms    <= PERIOD_RST;
			cfg_q.change_mv_threshold <= MV_THRESH_RST;
			cfg_q.change_ua_threshold <= UA_THRESH_RST;
			cfg_q.heartbeat_ms        <= HEARTBEAT_RST;
			cfg_q.recover_error_limit <= ERR_LIMIT_RST;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_ENABLE:    cfg_q.report_enable       <= cfg_data[0];
				REG_PERIOD:    cfg_q.report_period_ms    <= cfg_data[15:0];
				REG_MV_THRESH: cfg_q.change_mv_threshold <= cfg_data[16:0];
				REG_UA_THRESH: cfg_q.change_ua_threshold <= cfg_data[24:0];
				REG_HEARTBEAT: cfg_q.heartbeat_ms        <= cfg_data[30:0];
				REG_ERR_LIMIT: cfg_q.recover_error_limit <= cfg_data[3:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	pmrf_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.operation  (operation),
		.now_ms     (now_ms),
		.bus_raw    (bus_raw),
		.shunt_raw  (shunt_raw),
		.head_valid (head_valid),
		.head       (head),
		.head_pop   (head_pop)
	);

	pmrf_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg_q),
		.head_valid        (head_valid),
		.head              (head),
		.head_pop          (head_pop),
		.empty             (empty),
		.pop               (pop),
		.volts_mv          (volts_mv),
		.current_ua        (current_ua),
		.power_mw          (power_mw),
		.measurement_valid (measurement_valid),
		.report_now        (report_now),
		.recover_bus       (recover_bus)
	);

endmodule

@@ rtl/core/pmrf_checker.sv @@
// Port-level checks of the power monitor report filter, bound to the top level.
`include "power_monitor_report_filter_macros.svh"

module pmrf_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input logic [16:0]        volts_mv,
	input logic signed [24:0] current_ua,
	input logic signed [21:0] power_mw,
	input logic               measurement_valid,
	input logic               report_now,
	input logic               recover_bus
);

	// A report is only issued while a good measurement is held.
	`PMRF_ASSERT_IMP(a_report_needs_valid, !empty && report_now, measurement_valid, "report without valid measurement")

	// A recovery request comes from a failure, which drops the measurement.
	`PMRF_ASSERT_IMP(a_recover_drops_valid, !empty && recover_bus, !measurement_valid && !report_now, "recovery with valid measurement or report")

	// Nonzero power has the sign of the current it was computed from.
	`PMRF_ASSERT_IMP(a_power_sign, !empty && (power_mw != 22'sd0), power_mw[21] == current_ua[24], "power sign differs from current sign")

	// A result that is not popped stays on the ports.
	`PMRF_ASSERT_NXT(a_result_holds, !empty && !pop, !empty && $stable(volts_mv) && $stable(current_ua) && $stable(power_mw) && $stable(report_now), "waiting item changed")

endmodule

bind power_monitor_report_filter pmrf_checker u_pmrf_checker (.*);
